[rtl/mtc_pkg.sv]
`default_nettype none

package mtc_pkg;

  // opcodes of an input word
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADVANCE = 3'd1,
    OP_SET     = 3'd2,
    OP_STAMP   = 3'd3,
    OP_LOCATE  = 3'd4
  } opcode_t;

  typedef enum logic {
    MSG_QUARTER = 1'b0,
    MSG_FULL    = 1'b1
  } msg_kind_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
  } position_t;

  // one queued message: quarter frame uses piece_byte, full frame uses pos
  typedef struct packed {
    msg_kind_t  kind;
    logic [7:0] piece_byte;
    position_t  pos;
  } msg_t;

  typedef struct packed {
    logic push;
    msg_t msg;
  } push_t;

  localparam int         QUEUE_DEPTH_DEF = 2;
  localparam logic [7:0] INTERVAL_RESET  = 8'd40;
  localparam logic [8:0] ELAPSED_MAX     = 9'd511;
  localparam logic [4:0] FRAME_TOP       = 5'd24;
  localparam logic [5:0] SECOND_TOP      = 6'd59;
  localparam logic [5:0] MINUTE_TOP      = 6'd59;
  localparam logic [4:0] HOUR_TOP        = 5'd23;
  localparam logic [7:0] RATE_BITS       = 8'h20;

  localparam logic [7:0] QF_STATUS  = 8'hF1;
  localparam logic [7:0] SYX_START  = 8'hF0;
  localparam logic [7:0] SYX_ID     = 8'h7F;
  localparam logic [7:0] SYX_SUB    = 8'h01;
  localparam logic [7:0] SYX_END    = 8'hF7;

  localparam logic [3:0] QF_LAST_IDX   = 4'd1;
  localparam logic [3:0] FULL_LAST_IDX = 4'd9;

  function automatic logic [7:0] hour_byte(input position_t p);
    hour_byte = RATE_BITS | {3'b000, p.hours};
  endfunction

endpackage

`default_nettype wire

[rtl/mtc_front.sv]
`default_nettype none

module mtc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       opcode,
  input  wire logic [4:0]       set_hours,
  input  wire logic [5:0]       set_minutes,
  input  wire logic [5:0]       set_seconds,
  input  wire logic [4:0]       set_frames,
  input  wire logic             q_full,
  output mtc_pkg::push_t        push
);

  logic [7:0]         interval;
  logic [8:0]         elapsed, elapsed_next;
  logic [2:0]         piece, piece_next;
  mtc_pkg::position_t pos_now, pos_now_next;
  mtc_pkg::position_t pos_latched, pos_latched_next;

  logic               accept;
  mtc_pkg::opcode_t   op;
  mtc_pkg::position_t set_pos;
  mtc_pkg::position_t adv_pos;
  mtc_pkg::position_t qf_src;
  logic [8:0]         elapsed_inc;
  logic               qf_fire;
  logic [7:0]         qf_val;
  logic [3:0]         qf_nib;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign op       = mtc_pkg::opcode_t'(opcode);
  assign set_pos  = '{hours: set_hours, minutes: set_minutes,
                      seconds: set_seconds, frames: set_frames};

  // millisecond counter saturates at its top
  assign elapsed_inc = elapsed + {8'd0, (elapsed != mtc_pkg::ELAPSED_MAX)};
  assign qf_fire     = elapsed_inc > {1'b0, interval};

  // piece 0 takes a fresh copy of the position
  assign qf_src = (piece == 3'd0) ? pos_now : pos_latched;

  always_comb begin
    unique case (piece[2:1])
      2'd0: qf_val = {3'd0, qf_src.frames};
      2'd1: qf_val = {2'd0, qf_src.seconds};
      2'd2: qf_val = {2'd0, qf_src.minutes};
      default: qf_val = mtc_pkg::hour_byte(qf_src);
    endcase
    qf_nib = piece[0] ? qf_val[7:4] : qf_val[3:0];
  end

  // frame advance with wrap and carry; values at or over the top wrap too
  always_comb begin
    adv_pos = pos_now;
    if (pos_now.frames < mtc_pkg::FRAME_TOP) begin
      adv_pos.frames = pos_now.frames + 5'd1;
    end else begin
      adv_pos.frames = '0;
      if (pos_now.seconds < mtc_pkg::SECOND_TOP) begin
        adv_pos.seconds = pos_now.seconds + 6'd1;
      end else begin
        adv_pos.seconds = '0;
        if (pos_now.minutes < mtc_pkg::MINUTE_TOP) begin
          adv_pos.minutes = pos_now.minutes + 6'd1;
        end else begin
          adv_pos.minutes = '0;
          adv_pos.hours   = (pos_now.hours < mtc_pkg::HOUR_TOP) ?
                            pos_now.hours + 5'd1 : 5'd0;
        end
      end
    end
  end

  always_comb begin
    elapsed_next     = elapsed;
    piece_next       = piece;
    pos_now_next     = pos_now;
    pos_latched_next = pos_latched;
    push.push           = 1'b0;
    push.msg.kind       = mtc_pkg::MSG_FULL;
    push.msg.piece_byte = {1'b0, piece, qf_nib};
    push.msg.pos        = pos_now;
    if (accept) begin
      unique case (op)
        mtc_pkg::OP_TICK: begin
          if (qf_fire) begin
            elapsed_next     = elapsed_inc - {1'b0, interval};
            pos_latched_next = qf_src;
            piece_next       = piece + 3'd1;
            push.push        = 1'b1;
            push.msg.kind    = mtc_pkg::MSG_QUARTER;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
        mtc_pkg::OP_ADVANCE: begin
          pos_now_next = adv_pos;
        end
        mtc_pkg::OP_SET: begin
          pos_now_next = set_pos;
        end
        mtc_pkg::OP_STAMP: begin
          piece_next = '0;
          push.push  = 1'b1;
        end
        mtc_pkg::OP_LOCATE: begin
          pos_now_next = set_pos;
          piece_next   = '0;
          push.push    = 1'b1;
          push.msg.pos = set_pos;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval    <= mtc_pkg::INTERVAL_RESET;
      elapsed     <= '0;
      piece       <= '0;
      pos_now     <= '0;
      pos_latched <= '0;
    end else begin
      if (cfg_wen) begin
        interval <= cfg_wdata;
      end
      elapsed     <= elapsed_next;
      piece       <= piece_next;
      pos_now     <= pos_now_next;
      pos_latched <= pos_latched_next;
    end
  end

endmodule

`default_nettype wire

[rtl/mtc_queue.sv]
`default_nettype none

module mtc_queue #(
  parameter int DEPTH = mtc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtc_pkg::push_t push,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output mtc_pkg::msg_t       head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mtc_pkg::msg_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.msg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mtc_back.sv]
`default_nettype none

module mtc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mtc_pkg::msg_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         midi_byte,
  output logic               last_byte
);

  logic [3:0] idx;
  logic [7:0] byte_now;
  logic       last_now;
  logic       load;

  always_comb begin
    if (head.kind == mtc_pkg::MSG_QUARTER) begin
      byte_now = (idx == 4'd0) ? mtc_pkg::QF_STATUS : head.piece_byte;
      last_now = (idx == mtc_pkg::QF_LAST_IDX);
    end else begin
      unique case (idx)
        4'd0:       byte_now = mtc_pkg::SYX_START;
        4'd1, 4'd2: byte_now = mtc_pkg::SYX_ID;
        4'd3, 4'd4: byte_now = mtc_pkg::SYX_SUB;
        4'd5:       byte_now = mtc_pkg::hour_byte(head.pos);
        4'd6:       byte_now = {2'd0, head.pos.minutes};
        4'd7:       byte_now = {2'd0, head.pos.seconds};
        4'd8:       byte_now = {3'd0, head.pos.frames};
        default:    byte_now = mtc_pkg::SYX_END;
      endcase
      last_now = (idx == mtc_pkg::FULL_LAST_IDX);
    end
  end

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last_now ? 4'd0 : idx + 4'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      midi_byte <= byte_now;
      last_byte <= last_now;
    end
  end

endmodule

`default_nettype wire

[rtl/midi_timecode_generator.sv]
`default_nettype none

// midi timecode generator, 25 fps. each input word carries an opcode: ms tick,
// frame advance, position set, full-frame stamp, or locate (set then stamp).
// the front end takes one word per cycle while the message queue has room,
// updates the position, ms counter and quarter-frame piece index at once, and
// queues any message it causes. the back end sends queued messages one byte
// per cycle while out_ready is high, through a registered output stage: a
// quarter frame is 2 bytes, a full-frame sysex 10. the output byte rate of
// one per cycle is what bounds sustained rate when messages are dense;
// QUEUE_DEPTH sets how many messages may wait.
// the interval register is written through cfg_wen/cfg_wdata with no wait.
module midi_timecode_generator #(
  parameter int QUEUE_DEPTH = mtc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // interval register write
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  // input words
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] opcode,
  input  wire logic [4:0] set_hours,
  input  wire logic [5:0] set_minutes,
  input  wire logic [5:0] set_seconds,
  input  wire logic [4:0] set_frames,
  // output bytes
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      midi_byte,
  output logic            last_byte
);

  mtc_pkg::push_t push;
  mtc_pkg::msg_t  head;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // front end: state update and message classification
  mtc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .set_hours   (set_hours),
    .set_minutes (set_minutes),
    .set_seconds (set_seconds),
    .set_frames  (set_frames),
    .q_full      (q_full),
    .push        (push)
  );

  // message queue between the two halves
  mtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  // back end: byte serialiser and output register
  mtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .midi_byte (midi_byte),
    .last_byte (last_byte)
  );

`ifndef NO_ASSERTIONS
  // a stamp or locate always leaves a message waiting
  a_stamp_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (opcode == mtc_pkg::OP_STAMP || opcode == mtc_pkg::OP_LOCATE) |=> !q_empty)
    else $error("stamp accepted but queue empty");

  // a message ends either in sysex end or in a quarter-frame data byte
  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> (midi_byte == mtc_pkg::SYX_END) || !midi_byte[7])
    else $error("bad final byte");

  // input is held off exactly while the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    in_ready == !q_full)
    else $error("input ready disagrees with queue state");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

// bench for the 25 fps midi timecode generator: words go in through a queue-fed
// driver, bytes come out through a monitor that checks them against a local
// model of the position, ms counter and quarter-frame sequence
module tb;
  import mtc_pkg::*;

  // highest code the 3-bit opcode field can carry; codes above locate do nothing
  localparam logic [2:0] OP_TOP_CODE   = 3'd7;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         RUN_LIMIT_NS  = 6_000_000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [2:0] op;
    position_t  pos;
  } mtc_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } midi_out_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cfg_wen     = 1'b0;
  logic [7:0] cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [2:0] opcode      = '0;
  logic [4:0] set_hours   = '0;
  logic [5:0] set_minutes = '0;
  logic [5:0] set_seconds = '0;
  logic [4:0] set_frames  = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] midi_byte;
  logic       last_byte;

  // words still to be offered, and bytes the model says must come out
  mtc_word_t  words_to_send[$];
  midi_out_t  bytes_due[$];

  // model state, kept in step with accepted words
  logic [7:0] interval_ms = INTERVAL_RESET;
  logic [8:0] elapsed_ms  = '0;
  logic [2:0] piece_idx   = '0;
  position_t  tc_now      = '0;
  position_t  tc_latched  = '0;

  idle_mode_t idle_mode   = IDLE_NONE;
  int         mismatches  = 0;

  // long receiver hold-off: requested once by the phase sequence, counted below
  bit         hold_req    = 1'b0;
  bit         hold_taken  = 1'b0;
  int         hold_left   = 0;

  midi_timecode_generator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .set_hours  (set_hours),
    .set_minutes(set_minutes),
    .set_seconds(set_seconds),
    .set_frames (set_frames),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .midi_byte  (midi_byte),
    .last_byte  (last_byte)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs or drops bytes
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- model

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch: %s, got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    midi_out_t b;
    b.data = data;
    b.last = last;
    bytes_due.push_back(b);
  endtask

  // two-byte quarter frame; the whole eight-piece cycle reads the copy taken at piece 0
  task automatic send_quarter_frame();
    logic [7:0] val;
    logic [3:0] nib;
    if (piece_idx == 3'd0) tc_latched = tc_now;
    case (piece_idx[2:1])
      2'd0:    val = {3'b000, tc_latched.frames};
      2'd1:    val = {2'b00, tc_latched.seconds};
      2'd2:    val = {2'b00, tc_latched.minutes};
      default: val = RATE_BITS | {3'b000, tc_latched.hours};
    endcase
    nib = piece_idx[0] ? val[7:4] : val[3:0];
    push_byte(QF_STATUS, 1'b0);
    push_byte({1'b0, piece_idx, nib}, 1'b1);
    piece_idx = piece_idx + 3'd1;
  endtask

  // ten-byte full-frame sysex from the live position; restarts the piece cycle
  task automatic send_full_frame();
    push_byte(SYX_START, 1'b0);
    push_byte(SYX_ID, 1'b0);
    push_byte(SYX_ID, 1'b0);
    push_byte(SYX_SUB, 1'b0);
    push_byte(SYX_SUB, 1'b0);
    push_byte(RATE_BITS | {3'b000, tc_now.hours}, 1'b0);
    push_byte({2'b00, tc_now.minutes}, 1'b0);
    push_byte({2'b00, tc_now.seconds}, 1'b0);
    push_byte({3'b000, tc_now.frames}, 1'b0);
    push_byte(SYX_END, 1'b1);
    piece_idx = '0;
  endtask

  // anything at or past its top wraps to zero and carries, out-of-range values too
  task automatic step_frame();
    if (tc_now.frames < FRAME_TOP) begin
      tc_now.frames = tc_now.frames + 5'd1;
    end else begin
      tc_now.frames = '0;
      if (tc_now.seconds < SECOND_TOP) begin
        tc_now.seconds = tc_now.seconds + 6'd1;
      end else begin
        tc_now.seconds = '0;
        if (tc_now.minutes < MINUTE_TOP) begin
          tc_now.minutes = tc_now.minutes + 6'd1;
        end else begin
          tc_now.minutes = '0;
          tc_now.hours   = (tc_now.hours < HOUR_TOP) ? tc_now.hours + 5'd1 : 5'd0;
        end
      end
    end
  endtask

  task automatic compute_mtc_bytes(input logic [2:0] op, input position_t pos);
    case (op)
      OP_TICK: begin
        // counter saturates, then a message goes once it passes the interval
        if (elapsed_ms < ELAPSED_MAX) elapsed_ms = elapsed_ms + 9'd1;
        if (elapsed_ms > {1'b0, interval_ms}) begin
          elapsed_ms = elapsed_ms - {1'b0, interval_ms};
          send_quarter_frame();
        end
      end
      OP_ADVANCE: step_frame();
      OP_SET:     tc_now = pos;
      OP_STAMP:   send_full_frame();
      OP_LOCATE: begin
        tc_now = pos;
        send_full_frame();
      end
      default: ;  // unused codes leave everything alone
    endcase
  endtask

  // ---------------------------------------------------------------- driver and monitor

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99, 0) < 66;
      IDLE_BOTH: return $urandom_range(99, 0) < 26;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99, 0) < 66;
      IDLE_BOTH: return $urandom_range(99, 0) < 26;
      default:   return 1'b0;
    endcase
  endfunction

  // a new word is only put up once the previous one has gone, so valid never drops early
  always @(posedge clk) begin : drive_words
    mtc_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (words_to_send.size() != 0 && !sender_gap()) begin
        w = words_to_send.pop_front();
        in_valid    <= 1'b1;
        opcode      <= w.op;
        set_hours   <= w.pos.hours;
        set_minutes <= w.pos.minutes;
        set_seconds <= w.pos.seconds;
        set_frames  <= w.pos.frames;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // byte sink; the one long hold-off lets the message queue fill and back up the input
  always @(posedge clk) begin : accept_bytes
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_stall();
    end
  end

  // both handshakes sampled on the same edge the block sees them
  always @(posedge clk) begin : watch_ports
    midi_out_t due;
    if (!rst) begin
      if (in_valid && in_ready)
        compute_mtc_bytes(opcode, {set_hours, set_minutes, set_seconds, set_frames});
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          report_mismatch("byte with nothing due", midi_byte, 'x);
        end else begin
          due = bytes_due.pop_front();
          if (midi_byte !== due.data) report_mismatch("midi_byte", midi_byte, due.data);
          if (last_byte !== due.last)
            report_mismatch("last_byte", {7'd0, last_byte}, {7'd0, due.last});
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_word(input logic [2:0] op, input logic [4:0] hrs,
                            input logic [5:0] mins, input logic [5:0] secs,
                            input logic [4:0] frs);
    mtc_word_t w;
    w.op  = op;
    w.pos = {hrs, mins, secs, frs};
    words_to_send.push_back(w);
  endtask

  // mostly legal positions, sometimes raw bits so every field bit and range gets hit
  function automatic position_t random_position();
    position_t p;
    if ($urandom_range(99, 0) < 20) begin
      {p.hours, p.minutes, p.seconds, p.frames} = 22'($urandom);
    end else begin
      p.hours   = 5'($urandom_range(23, 0));
      p.minutes = 6'($urandom_range(59, 0));
      p.seconds = 6'($urandom_range(59, 0));
      p.frames  = 5'($urandom_range(24, 0));
    end
    return p;
  endfunction

  task automatic queue_random_words(input int count, input int tick_pct);
    mtc_word_t w;
    int roll;
    repeat (count) begin
      w.pos = random_position();
      if ($urandom_range(99, 0) < tick_pct) begin
        w.op = OP_TICK;
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 35)      w.op = OP_ADVANCE;
        else if (roll < 55) w.op = OP_SET;
        else if (roll < 75) w.op = OP_STAMP;
        else if (roll < 93) w.op = OP_LOCATE;
        else                w.op = 3'($urandom_range(OP_TOP_CODE, OP_LOCATE + 1));
      end
      words_to_send.push_back(w);
    end
  endtask

  // idle means nothing left to offer, nothing due, and a settling wait for words
  // that produced no bytes to finish inside the block
  task automatic wait_drained();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_valid || bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [7:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    interval_ms  = value;
    @(negedge clk);
  endtask

  initial begin : run_phases
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset interval: rate code before any set, wraps, out-of-range
    // fields, unused codes
    idle_mode = IDLE_NONE;
    queue_word(OP_STAMP, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(3'(OP_LOCATE + 1), 5'h1F, 6'h3F, 6'h3F, 5'h1F);
    queue_word(3'(OP_LOCATE + 2), 5'h0A, 6'h15, 6'h2A, 5'h15);
    queue_word(OP_TOP_CODE, 5'h15, 6'h2A, 6'h15, 5'h0A);
    queue_word(OP_LOCATE, HOUR_TOP, MINUTE_TOP, SECOND_TOP, FRAME_TOP);
    queue_word(OP_ADVANCE, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_STAMP, 5'h1F, 6'h3F, 6'h3F, 5'h1F);
    queue_word(OP_SET, 5'h1F, 6'h3F, 6'h3F, 5'h1F);
    queue_word(OP_STAMP, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_ADVANCE, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_STAMP, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_SET, 5'd16, MINUTE_TOP, 6'd32, FRAME_TOP);
    queue_word(OP_ADVANCE, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_LOCATE, 5'd16, 6'd32, 6'd32, 5'd16);
    wait_drained();

    // interval zero: every tick sends; the set in mid-cycle must not show until piece 0
    write_interval(8'd0);
    queue_word(OP_SET, 5'd12, 6'd34, 6'd56, 5'd7);
    repeat (4) queue_word(OP_TICK, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_SET, 5'd1, 6'd2, 6'd3, 5'd4);
    repeat (5) queue_word(OP_TICK, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_word(OP_STAMP, 5'd0, 6'd0, 6'd0, 5'd0);
    repeat (3) queue_word(OP_TICK, 5'd0, 6'd0, 6'd0, 5'd0);
    wait_drained();

    // random phases, one idling pattern and one interval each
    write_interval(8'd1);
    idle_mode = IDLE_NONE;
    queue_random_words(30, 60);
    wait_drained();

    // widest interval: ticks pile up in the counter with few quarter frames
    write_interval(8'd255);
    idle_mode = IDLE_SEND;
    queue_random_words(60, 96);
    wait_drained();

    write_interval(8'($urandom_range(30, 2)));
    idle_mode = IDLE_RECV;
    queue_random_words(30, 60);
    wait_drained();

    write_interval(8'd3);
    idle_mode = IDLE_BOTH;
    queue_random_words(30, 55);
    wait_drained();

    // back-pressure: sink holds off while stamps keep arriving
    write_interval(INTERVAL_RESET);
    idle_mode = IDLE_NONE;
    hold_req  = 1'b1;
    repeat (8) queue_word(OP_STAMP, 5'd0, 6'd0, 6'd0, 5'd0);
    queue_random_words(15, 40);
    wait_drained();

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
